// File: rtl/core/arp_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and constants for the ARM relocation patcher.
// Used by every file under rtl/core; depends on nothing.

package arp_pkg;

    localparam int KIND_W    = 8;
    localparam int SYM_W     = 24;
    localparam int WORD_W    = 32;
    localparam int ST_W      = 3;
    localparam int CFG_IDX_W = 2;
    localparam int OP_W      = 3;

    // Default depth of the queue between classification and patching.
    localparam int QUEUE_DEPTH = 2;

    // Relocation type numbers.
    localparam logic [KIND_W-1:0] KIND_NONE   = 8'd0;
    localparam logic [KIND_W-1:0] KIND_PC24   = 8'd1;
    localparam logic [KIND_W-1:0] KIND_ABS32  = 8'd2;
    localparam logic [KIND_W-1:0] KIND_CALL   = 8'd28;
    localparam logic [KIND_W-1:0] KIND_JUMP24 = 8'd29;
    localparam logic [KIND_W-1:0] KIND_V4BX   = 8'd40;
    localparam logic [KIND_W-1:0] KIND_PREL31 = 8'd42;
    localparam logic [KIND_W-1:0] KIND_MOVW   = 8'd43;
    localparam logic [KIND_W-1:0] KIND_MOVT   = 8'd44;

    // Status codes.
    localparam logic [ST_W-1:0] ST_OK      = 3'd0;
    localparam logic [ST_W-1:0] ST_BAD_SYM = 3'd1;
    localparam logic [ST_W-1:0] ST_BOUNDS  = 3'd2;
    localparam logic [ST_W-1:0] ST_RANGE   = 3'd3;
    localparam logic [ST_W-1:0] ST_UNKNOWN = 3'd4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_SYMBOL_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SECTION_SIZE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SECTION_BASE = 2'd2;

    typedef logic [OP_W-1:0] op_t;

    // Operation classes decided by the front end.
    localparam op_t OP_NONE   = 3'd0;
    localparam op_t OP_ABS32  = 3'd1;
    localparam op_t OP_BRANCH = 3'd2;
    localparam op_t OP_V4BX   = 3'd3;
    localparam op_t OP_PREL31 = 3'd4;
    localparam op_t OP_MOVW   = 3'd5;
    localparam op_t OP_MOVT   = 3'd6;

    localparam logic [WORD_W-1:0] V4BX_KEEP  = 32'hf000000f;
    localparam logic [WORD_W-1:0] V4BX_SET   = 32'h01a0f000;
    localparam logic [WORD_W-1:0] MOV_KEEP   = 32'hfff0f000;
    localparam logic [WORD_W-1:0] WORD_BYTES = 32'd4;

    // One classified relocation waiting to be patched.
    typedef struct packed {
        op_t               op;
        logic [ST_W-1:0]   status;
        logic [WORD_W-1:0] symbol_value;
        logic [WORD_W-1:0] place_address;
        logic [WORD_W-1:0] original_word;
    } entry_t;

endpackage

// File: rtl/core/arp_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for relocation requests and patch results.
// Depends on arp_pkg for field widths.

interface arp_req_if;
    logic                          valid;
    logic                          ready;
    logic [arp_pkg::KIND_W-1:0]    reloc_kind;
    logic [arp_pkg::SYM_W-1:0]     symbol_index;
    logic [arp_pkg::WORD_W-1:0]    symbol_value;
    logic [arp_pkg::WORD_W-1:0]    place_offset;
    logic [arp_pkg::WORD_W-1:0]    original_word;

    modport source (
        output valid, reloc_kind, symbol_index, symbol_value, place_offset, original_word,
        input  ready
    );
    modport sink (
        input  valid, reloc_kind, symbol_index, symbol_value, place_offset, original_word,
        output ready
    );
endinterface

interface arp_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [arp_pkg::WORD_W-1:0]    patched_word;
    logic [arp_pkg::WORD_W-1:0]    place_address;
    logic                          write_back;
    logic [arp_pkg::ST_W-1:0]      status;

    modport source (
        output valid, patched_word, place_address, write_back, status,
        input  ready
    );
    modport sink (
        input  valid, patched_word, place_address, write_back, status,
        output ready
    );
endinterface

// File: rtl/core/arp_front.sv
`timescale 1ns / 1ps
// Front end: holds the configuration registers, accepts requests, forms the
// place address and runs the symbol, bounds and type checks. Uses arp_pkg.

module arp_front
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [arp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [arp_pkg::WORD_W-1:0]        cfg_data,
    arp_req_if.sink                           req,
    output logic                              push,
    output arp_pkg::entry_t                   push_entry,
    input  logic                              push_ready
);

    logic [arp_pkg::SYM_W-1:0]  symbol_count_reg;
    logic [arp_pkg::WORD_W-1:0] section_size_reg;
    logic [arp_pkg::WORD_W-1:0] section_base_reg;

    logic                       valid_reg;
    logic                       valid_next;
    arp_pkg::entry_t            entry_reg;
    arp_pkg::entry_t            entry_next;

    logic                       accept;
    logic                       bad_sym;
    logic                       out_of_bounds;
    logic                       unknown;
    arp_pkg::op_t               op;
    logic [arp_pkg::WORD_W-1:0] size_limit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            symbol_count_reg <= '0;
            section_size_reg <= '0;
            section_base_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                arp_pkg::REG_SYMBOL_COUNT: symbol_count_reg <= cfg_data[arp_pkg::SYM_W-1:0];
                arp_pkg::REG_SECTION_SIZE: section_size_reg <= cfg_data;
                arp_pkg::REG_SECTION_BASE: section_base_reg <= cfg_data;
                default:                   ;
            endcase
        end
    end

    assign req.ready = !valid_reg || push_ready;
    assign accept    = req.valid && req.ready;
    assign push      = valid_reg && push_ready;

    always_comb
    begin
        unknown = 1'b0;
        case (req.reloc_kind) inside
            arp_pkg::KIND_NONE:   op = arp_pkg::OP_NONE;
            arp_pkg::KIND_ABS32:  op = arp_pkg::OP_ABS32;
            arp_pkg::KIND_PC24,
            arp_pkg::KIND_CALL,
            arp_pkg::KIND_JUMP24: op = arp_pkg::OP_BRANCH;
            arp_pkg::KIND_V4BX:   op = arp_pkg::OP_V4BX;
            arp_pkg::KIND_PREL31: op = arp_pkg::OP_PREL31;
            arp_pkg::KIND_MOVW:   op = arp_pkg::OP_MOVW;
            arp_pkg::KIND_MOVT:   op = arp_pkg::OP_MOVT;
            default:
            begin
                op      = arp_pkg::OP_NONE;
                unknown = 1'b1;
            end
        endcase
    end

    assign size_limit    = section_size_reg - arp_pkg::WORD_BYTES;
    assign bad_sym       = req.symbol_index >= symbol_count_reg;
    assign out_of_bounds = (section_size_reg < arp_pkg::WORD_BYTES)
                           || (req.place_offset > size_limit);

    always_comb
    begin
        entry_next               = entry_reg;
        entry_next.op            = op;
        entry_next.symbol_value  = req.symbol_value;
        entry_next.place_address = section_base_reg + req.place_offset;
        entry_next.original_word = req.original_word;
        // The first failing check decides the status; branch range is left
        // to the back end.
        if (bad_sym)
        begin
            entry_next.status = arp_pkg::ST_BAD_SYM;
        end
        else if (out_of_bounds)
        begin
            entry_next.status = arp_pkg::ST_BOUNDS;
        end
        else if (unknown)
        begin
            entry_next.status = arp_pkg::ST_UNKNOWN;
        end
        else
        begin
            entry_next.status = arp_pkg::ST_OK;
        end
    end

    always_comb
    begin
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (push)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            entry_reg <= entry_next;
        end
    end

    assign push_entry = entry_reg;

endmodule

// File: rtl/core/arp_queue.sv
`timescale 1ns / 1ps
// Small register queue that decouples the front end from the back end.
// Holds arp_pkg::entry_t words; depends on arp_pkg.

module arp_queue
#(
    parameter int DEPTH = arp_pkg::QUEUE_DEPTH
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  arp_pkg::entry_t push_entry,
    output logic            push_ready,
    input  logic            pop,
    output arp_pkg::entry_t head,
    output logic            head_valid
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL = CNT_W'(DEPTH);

    arp_pkg::entry_t  mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign push_ready = count_reg != FULL;
    assign head_valid = count_reg != '0;
    assign head       = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// File: rtl/core/arp_back.sv
`timescale 1ns / 1ps
// Back end: computes the patched word for the entry at the head of the
// queue, checks branch range and registers the result. Uses arp_pkg.

module arp_back
(
    input  logic            clk,
    input  logic            rst_n,
    input  arp_pkg::entry_t head,
    input  logic            head_valid,
    output logic            pop,
    arp_rsp_if.source       rsp
);

    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic [arp_pkg::WORD_W-1:0] patched_word_reg;
    logic [arp_pkg::WORD_W-1:0] place_address_reg;
    logic                       write_back_reg;
    logic [arp_pkg::ST_W-1:0]   status_reg;

    logic [arp_pkg::WORD_W-1:0] w;
    logic [arp_pkg::WORD_W-1:0] branch_addend;
    logic [arp_pkg::WORD_W-1:0] sum_a;
    logic [arp_pkg::WORD_W-1:0] sum;
    logic                       branch_ok;
    logic [arp_pkg::WORD_W-1:0] mov_value;
    logic [15:0]                mov_imm;
    logic [arp_pkg::WORD_W-1:0] word_next;
    logic                       write_next;
    logic [arp_pkg::ST_W-1:0]   status_next;

    assign w = head.original_word;

    // Branch offset field scaled to bytes and sign extended from bit 25.
    assign branch_addend = {{6{w[23]}}, w[23:0], 2'b00};

    // Branches and PREL31 share one three-input adder: A + S - P.
    assign sum_a = (head.op == arp_pkg::OP_BRANCH) ? branch_addend : w;
    assign sum   = sum_a + head.symbol_value - head.place_address;

    // In range means word aligned and strictly inside plus or minus 2^25.
    assign branch_ok = (sum[1:0] == 2'b00)
                       && ((sum[31:25] == 7'h00)
                           || ((sum[31:25] == 7'h7f) && (sum[24:0] != '0)));

    assign mov_value = {{16{w[19]}}, w[19:16], w[11:0]} + head.symbol_value;
    assign mov_imm   = (head.op == arp_pkg::OP_MOVT) ? mov_value[31:16] : mov_value[15:0];

    always_comb
    begin
        word_next   = w;
        write_next  = 1'b0;
        status_next = head.status;
        if (head.status == arp_pkg::ST_OK)
        begin
            case (head.op)
                arp_pkg::OP_ABS32:
                begin
                    word_next  = w + head.symbol_value;
                    write_next = 1'b1;
                end
                arp_pkg::OP_BRANCH:
                begin
                    if (branch_ok)
                    begin
                        word_next  = {w[31:24], sum[25:2]};
                        write_next = 1'b1;
                    end
                    else
                    begin
                        status_next = arp_pkg::ST_RANGE;
                    end
                end
                arp_pkg::OP_V4BX:
                begin
                    word_next  = (w & arp_pkg::V4BX_KEEP) | arp_pkg::V4BX_SET;
                    write_next = 1'b1;
                end
                arp_pkg::OP_PREL31:
                begin
                    word_next  = {w[31], sum[30:0]};
                    write_next = 1'b1;
                end
                arp_pkg::OP_MOVW,
                arp_pkg::OP_MOVT:
                begin
                    word_next  = (w & arp_pkg::MOV_KEEP)
                                 | {12'h000, mov_imm[15:12], 4'h0, mov_imm[11:0]};
                    write_next = 1'b1;
                end
                default:
                begin
                    word_next = w;
                end
            endcase
        end
    end

    assign pop = head_valid && (!out_valid_reg || rsp.ready);

    always_comb
    begin
        if (pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            patched_word_reg  <= word_next;
            place_address_reg <= head.place_address;
            write_back_reg    <= write_next;
            status_reg        <= status_next;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.patched_word  = patched_word_reg;
    assign rsp.place_address = place_address_reg;
    assign rsp.write_back    = write_back_reg;
    assign rsp.status        = status_reg;

endmodule

// File: rtl/core/arm_relocation_patcher.sv
`timescale 1ns / 1ps
// A request word is held in the front register, then a queue slot, then the
// output register, where its result word is presented on rsp.
// Throughput: one relocation per cycle while rsp.ready stays high; request
// ready depends only on the front register and queue fill, so either side may
// stall independently.
// Reset (rst_n, asynchronous): configuration registers go to zero, all valid
// flags and queue pointers clear.

module arm_relocation_patcher
#(
    parameter int QUEUE_DEPTH = arp_pkg::QUEUE_DEPTH
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [arp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [arp_pkg::WORD_W-1:0]    cfg_data,
    arp_req_if.sink                       req,
    arp_rsp_if.source                     rsp
);

    logic            push;
    logic            push_ready;
    arp_pkg::entry_t push_entry;
    logic            pop;
    logic            head_valid;
    arp_pkg::entry_t head;

    arp_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .req        (req),
        .push       (push),
        .push_entry (push_entry),
        .push_ready (push_ready)
    );

    arp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .push_ready (push_ready),
        .pop        (pop),
        .head       (head),
        .head_valid (head_valid)
    );

    arp_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop),
        .rsp        (rsp)
    );

endmodule
